FILE: hdl/pn2d_pkg.sv
// Package for the 2D gradient noise pipeline: formats, hash constants and
// the quarter-turn gradient tables built at elaboration.
// Used by perlin_noise_2d; depends on nothing.
package pn2d_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int ANGLE_BITS = 10;
	localparam int QBITS      = ANGLE_BITS - 2;
	localparam int QN         = 1 << QBITS;
	localparam int GW         = 17;
	localparam int NW         = 33;
	localparam int DOT_SH     = FRAC_BITS - 15;
	localparam int DOT_SHR    = (DOT_SH > 0) ? DOT_SH : 0;
	localparam int DOT_SHL    = (DOT_SH > 0) ? 0 : -DOT_SH;

	localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
	localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
	localparam logic [31:0] HASH_MUL_C = 32'd2048419325;
	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	typedef logic [QN-1:0][GW-1:0] lut_t;

	function automatic logic [63:0] horner(input logic [63:0] x2, input logic is_sin);
		logic [63:0] acc;
		logic [63:0] p;
		logic [63:0] sub;
		int n;
		acc = Q30_ONE;
		n = is_sin ? 6 : 7;
		for (int i = 0; i < 7; i++) begin
			if (i < n) begin
				p = (x2 * acc) >> 30;
				if (is_sin) begin
					unique case (i)
						0: sub = p / 156;
						1: sub = p / 110;
						2: sub = p / 72;
						3: sub = p / 42;
						4: sub = p / 20;
						default: sub = p / 6;
					endcase
				end else begin
					unique case (i)
						0: sub = p / 182;
						1: sub = p / 132;
						2: sub = p / 90;
						3: sub = p / 56;
						4: sub = p / 30;
						5: sub = p / 12;
						default: sub = p / 2;
					endcase
				end
				acc = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
			end
		end
		return acc;
	endfunction

	function automatic lut_t build_lut(input logic is_sin);
		lut_t lut;
		logic [63:0] t;
		logic [63:0] x2;
		logic [63:0] v;
		for (int r = 0; r < QN; r++) begin
			t = (64'(r) * Q30_HALF_PI) >> QBITS;
			x2 = (t * t) >> 30;
			if (is_sin)
				v = (t * horner(x2, 1'b1)) >> 30;
			else
				v = horner(x2, 1'b0);
			v = (v + 64'd16384) >> 15;
			lut[r] = v[GW-1:0];
		end
		return lut;
	endfunction

endpackage

FILE: hdl/perlin_noise_2d.sv
// 2D gradient noise, one point per cycle when not stalled, ten register stages.
// Uses pn2d_pkg for formats, hash constants and gradient tables.
//
// Input channel: coord_x, coord_y (signed fixed point, FRAC_BITS fraction
// bits) with coord_valid / coord_stall. Output channel: noise_value (signed
// Q1.15, saturated) with noise_valid / noise_stall. A word moves on a rising
// edge where valid is high and stall is low.
// Throughput is one word per cycle while the output is not stalled, set by
// the fully pipelined hash multipliers (one per column, two per corner), the
// gradient table lookup, the dot products and the x and y lerps.
// The block keeps no state between words.
// Reset (arst_n low) clears all stage valid bits at once; the pipeline is
// empty afterwards and accepts a word in the first cycle.
// When noise_stall holds a valid output, the whole pipeline freezes and
// coord_stall rises in the same cycle; nothing is lost or repeated, and
// bubbles keep moving while the output register is empty.
module perlin_noise_2d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        coord_valid,
	output logic        coord_stall,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	output logic        noise_valid,
	input  logic        noise_stall,
	output logic [15:0] noise_value
);

	localparam int F  = pn2d_pkg::FRAC_BITS;
	localparam int GW = pn2d_pkg::GW;
	localparam int NW = pn2d_pkg::NW;
	localparam int DW = F + GW + 2;
	localparam int XW = 48;
	localparam int LW = NW + 1;
	localparam int PW = LW + F + 1;
	localparam int MW = LW + 1;
	localparam int QW = MW + F + 1;
	localparam pn2d_pkg::lut_t COS_LUT = pn2d_pkg::build_lut(1'b0);
	localparam pn2d_pkg::lut_t SIN_LUT = pn2d_pkg::build_lut(1'b1);

	logic adv;
	logic [10:1] v_s;

	logic [31:0] cx_s1, cy_s1;
	logic [31:0] ax_s2 [2];
	logic [31:0] y_s2 [2];
	logic [31:0] ax_s3 [2];
	logic [31:0] b_s3 [4];
	logic [31:0] h_s4 [4];
	logic signed [GW-1:0] gx_s5 [4];
	logic signed [GW-1:0] gy_s5 [4];
	logic signed [NW-1:0] n_s6 [4];
	logic signed [NW-1:0] a_s7 [2];
	logic signed [PW-1:0] p_s7 [2];
	logic signed [LW-1:0] ix_s8 [2];
	logic signed [LW-1:0] a_s9;
	logic signed [QW-1:0] p_s9;
	logic [F-1:0] fx_s2, fx_s3, fx_s4, fx_s5, fx_s6;
	logic [F-1:0] fy_s2, fy_s3, fy_s4, fy_s5, fy_s6, fy_s7, fy_s8;
	logic [15:0] out_s10;

	logic [31:0] x0_c, y0_c;
	logic [31:0] b_c [4];
	logic [31:0] h_c [4];
	logic signed [GW-1:0] gx_c [4];
	logic signed [GW-1:0] gy_c [4];
	logic signed [NW-1:0] n_c [4];
	logic signed [PW-1:0] p_c [2];
	logic signed [LW-1:0] ix_c [2];
	logic signed [QW-1:0] pv_c;
	logic [15:0] out_c;

	assign adv = !(v_s[10] && noise_stall);
	assign coord_stall = !adv;
	assign noise_valid = v_s[10];
	assign noise_value = out_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[9:1], coord_valid};
		end
	end

	always_comb begin
		logic [pn2d_pkg::ANGLE_BITS-1:0] idx;
		logic [1:0] q;
		logic [pn2d_pkg::QBITS-1:0] r;
		logic signed [GW-1:0] c, s;
		logic signed [F:0] dx, dy;
		logic signed [DW-1:0] dot;
		logic signed [XW-1:0] dw;
		logic signed [PW:0] rp;
		logic signed [QW:0] rq;
		logic signed [QW:0] vv;
		logic signed [QW:0] rr;

		x0_c = 32'($signed(cx_s1) >>> F);
		y0_c = 32'($signed(cy_s1) >>> F);

		for (int k = 0; k < 4; k++) begin
			b_c[k] = (y_s2[k/2] ^ {ax_s2[k%2][15:0], ax_s2[k%2][31:16]})
				* pn2d_pkg::HASH_MUL_B;
			h_c[k] = (ax_s3[k%2] ^ {b_s3[k][15:0], b_s3[k][31:16]})
				* pn2d_pkg::HASH_MUL_C;

			idx = h_s4[k][31 -: pn2d_pkg::ANGLE_BITS];
			q = idx[pn2d_pkg::ANGLE_BITS-1 -: 2];
			r = idx[pn2d_pkg::QBITS-1:0];
			c = $signed(COS_LUT[r]);
			s = $signed(SIN_LUT[r]);
			unique case (q)
				2'd0: begin gx_c[k] = c;  gy_c[k] = s;  end
				2'd1: begin gx_c[k] = -s; gy_c[k] = c;  end
				2'd2: begin gx_c[k] = -c; gy_c[k] = -s; end
				default: begin gx_c[k] = s; gy_c[k] = -c; end
			endcase

			dx = (k % 2 == 1) ? $signed({1'b1, fx_s5}) : $signed({1'b0, fx_s5});
			dy = (k / 2 == 1) ? $signed({1'b1, fy_s5}) : $signed({1'b0, fy_s5});
			dot = DW'(dx * gx_s5[k]) + DW'(dy * gy_s5[k]);
			dw = XW'(dot) + XW'(pn2d_pkg::DOT_SH > 0 ?
				(64'sd1 <<< (pn2d_pkg::DOT_SHR > 0 ? pn2d_pkg::DOT_SHR - 1 : 0)) : 64'sd0);
			dw = (dw >>> pn2d_pkg::DOT_SHR) <<< pn2d_pkg::DOT_SHL;
			n_c[k] = NW'(dw);
		end

		for (int j = 0; j < 2; j++) begin
			p_c[j] = PW'((LW'(n_s6[2*j+1]) - LW'(n_s6[2*j])) * $signed({1'b0, fx_s6}));
			rp = (PW+1)'(p_s7[j]) + (PW+1)'(64'sd1 <<< (F - 1));
			ix_c[j] = LW'(a_s7[j]) + LW'(rp >>> F);
		end

		pv_c = QW'((MW'(ix_s8[1]) - MW'(ix_s8[0])) * $signed({1'b0, fy_s8}));
		rq = (QW+1)'(p_s9) + (QW+1)'(64'sd1 <<< (F - 1));
		vv = (QW+1)'(a_s9) + (rq >>> F) + (QW+1)'(16384);
		rr = vv >>> 15;
		if (rr > (QW+1)'(32767))
			out_c = 16'h7fff;
		else if (rr < -(QW+1)'(32768))
			out_c = 16'h8000;
		else
			out_c = rr[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1 <= coord_x;
			cy_s1 <= coord_y;

			ax_s2[0] <= x0_c * pn2d_pkg::HASH_MUL_A;
			ax_s2[1] <= (x0_c + 32'd1) * pn2d_pkg::HASH_MUL_A;
			y_s2[0] <= y0_c;
			y_s2[1] <= y0_c + 32'd1;
			fx_s2 <= cx_s1[F-1:0];
			fy_s2 <= cy_s1[F-1:0];

			ax_s3 <= ax_s2;
			b_s3 <= b_c;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;

			h_s4 <= h_c;
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;

			gx_s5 <= gx_c;
			gy_s5 <= gy_c;
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;

			n_s6 <= n_c;
			fx_s6 <= fx_s5;
			fy_s6 <= fy_s5;

			a_s7[0] <= n_s6[0];
			a_s7[1] <= n_s6[2];
			p_s7 <= p_c;
			fy_s7 <= fy_s6;

			ix_s8 <= ix_c;
			fy_s8 <= fy_s7;

			a_s9 <= ix_s8[0];
			p_s9 <= pv_c;

			out_s10 <= out_c;
		end
	end

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(coord_valid && !coord_stall) |=> v_s[1])
		else $error("accepted word did not enter stage 1");

	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[9] && !coord_stall) |=> noise_valid)
		else $error("word lost before output register");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |=> $stable(v_s[9:1]))
		else $error("pipeline moved while output held");

endmodule
